>>> design/lpd_pkg.sv
// Shared types, constants and helpers of the laser scanner point decoder.
package lpd_pkg;

  localparam int HDR_W  = 16;
  localparam int RAW_W  = 16;
  localparam int SLOT_W = 5;
  localparam int AZ_W   = 16;
  localparam int DIFF_W = 15;
  localparam int PROD_W = 20;
  localparam int SUM_W  = 19;
  localparam int DIST_W = 18;
  localparam int STR_W  = 8;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROTOCOL_MODE = 2'd0,
    CFG_MIN_RANGE     = 2'd1,
    CFG_MAX_RANGE     = 2'd2,
    CFG_HEADER_MARKER = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic              protocol_mode;
    logic [DIST_W-1:0] min_range_mm;
    logic [DIST_W-1:0] max_range_mm;
    logic [HDR_W-1:0]  header_marker;
  } lpd_cfg_t;

  localparam logic              RST_PROTOCOL_MODE = 1'b1;
  localparam logic [DIST_W-1:0] RST_MIN_RANGE     = 18'd300;
  localparam logic [DIST_W-1:0] RST_MAX_RANGE     = 18'd100000;
  localparam logic [HDR_W-1:0]  RST_HEADER_MARKER = 16'hEEFF;

  // Azimuth constants in 0.01 degree units.
  localparam logic [AZ_W-1:0]  AZ_FULL    = 16'd36000;
  localparam logic [AZ_W-1:0]  AZ_HALF    = 16'd18000;
  localparam logic [AZ_W-1:0]  WRAP_HIGH  = 16'd35000;
  localparam logic [AZ_W-1:0]  WRAP_LOW   = 16'd1000;

  // floor(p / 30) = (p * DIV30_RECIP) >> DIV30_SHIFT, exact for p < 2**20.
  localparam int                DIV30_RECIP_W = 21;
  localparam logic [DIV30_RECIP_W-1:0] DIV30_RECIP = 21'd1118482;
  localparam int                DIV30_SHIFT   = 25;
  localparam int                DIV30_PROD_W  = PROD_W + DIV30_RECIP_W;

  // Number of full turns held by a sum that stays below 9 turns.
  localparam int TURN_W    = 4;
  localparam int MAX_TURNS = 8;

  // Offset of m full turns.
  function automatic logic [SUM_W-1:0] turn_base(input logic [TURN_W-1:0] m);
    return SUM_W'(m) * SUM_W'(AZ_FULL);
  endfunction

endpackage

>>> design/lpd_ifs.sv
// Valid/ready channel interfaces for raw points and decoded points.
interface lpd_raw_if;
  logic                         valid;
  logic                         ready;
  logic [lpd_pkg::HDR_W-1:0]    block_header;
  logic [lpd_pkg::RAW_W-1:0]    block_azimuth;
  logic [lpd_pkg::RAW_W-1:0]    neighbor_azimuth;
  logic [lpd_pkg::SLOT_W-1:0]   point_slot;
  logic [lpd_pkg::RAW_W-1:0]    distance_raw;
  logic [lpd_pkg::STR_W-1:0]    echo_strength;

  modport source (output valid, block_header, block_azimuth, neighbor_azimuth,
                  point_slot, distance_raw, echo_strength, input ready);
  modport sink   (input valid, block_header, block_azimuth, neighbor_azimuth,
                  point_slot, distance_raw, echo_strength, output ready);
endinterface

interface lpd_point_if #(
  parameter int MAX_POINTS = 4096
);
  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  logic                        valid;
  logic                        ready;
  logic [lpd_pkg::AZ_W-1:0]    pt_azimuth;
  logic [lpd_pkg::DIST_W-1:0]  distance_mm;
  logic [lpd_pkg::STR_W-1:0]   point_strength;
  logic [IDX_W-1:0]            point_index;
  logic                        revolution_end;
  logic [CNT_W-1:0]            revolution_points;

  modport source (output valid, pt_azimuth, distance_mm, point_strength,
                  point_index, revolution_end, revolution_points, input ready);
  modport sink   (input valid, pt_azimuth, distance_mm, point_strength,
                  point_index, revolution_end, revolution_points, output ready);
endinterface

>>> design/lidar_point_decoder.sv
// Top level of the laser scanner point decoder: six-register datapath.
//
// Usage:
//   raw_point carries one raw point per word (header, block azimuth,
//   neighbor azimuth, slot, raw distance, intensity). decoded_point carries
//   one decoded point per word. Both use valid/ready; a word moves at a
//   rising edge with valid and ready high. Words whose header differs from
//   header_marker are accepted and dropped without a result.
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_data);
//   write it only while no point is in flight.
// Throughput and pipeline:
//   One point per cycle while decoded_point.ready stays high. A kept point
//   passes the input register, fold/difference, slot product, divide by
//   the half-block point count and add, modulo one turn and the result
//   register, in that order, before it shows on decoded_point.
// Reset:
//   rst (synchronous) empties the datapath, reloads the configuration
//   defaults and clears the previous azimuth and the revolution counter.
// Stall:
//   When decoded_point.ready is low the result register holds; stages behind
//   it keep filling any bubbles, and raw_point.ready drops only when every
//   stage is full.
module lidar_point_decoder #(
  parameter int MAX_POINTS = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  lpd_raw_if.sink                        raw_point,
  lpd_point_if.source                    decoded_point,
  input  logic                           cfg_we,
  input  logic [lpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lpd_pkg::DIST_W-1:0]     cfg_data
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_POINTS);
  localparam logic [CNT_W-1:0] IDX_LAST = CNT_W'(MAX_POINTS - 1);

  lpd_pkg::lpd_cfg_t cfg;

  lpd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Stage valid bits and advance enables; a stage loads when it is empty
  // or the stage after it loads.
  logic v1, v2, v3, v4, v5, vo;
  logic adv1, adv2, adv3, adv4, adv5, advo;

  assign advo = !vo || decoded_point.ready;
  assign adv5 = !v5 || advo;
  assign adv4 = !v4 || adv5;
  assign adv3 = !v3 || adv4;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign raw_point.ready = adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      // Drop points from foreign blocks right at the input.
      if (adv1) v1 <= raw_point.valid &&
                      (raw_point.block_header == cfg.header_marker);
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) v4 <= v3;
      if (adv5) v5 <= v4;
    end
  end

  // Stage 1: input register.
  logic [lpd_pkg::RAW_W-1:0]  s1_az, s1_nb, s1_dist;
  logic [lpd_pkg::SLOT_W-1:0] s1_slot;
  logic [lpd_pkg::STR_W-1:0]  s1_str;

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_az   <= raw_point.block_azimuth;
      s1_nb   <= raw_point.neighbor_azimuth;
      s1_slot <= raw_point.point_slot;
      s1_dist <= raw_point.distance_raw;
      s1_str  <= raw_point.echo_strength;
    end
  end

  // Stage 2: fold both azimuths once, take the shorter way around,
  // scale and gate the distance.
  logic [lpd_pkg::AZ_W-1:0]   fold_a, fold_b, diff, diff_short;
  logic [lpd_pkg::DIST_W-1:0] dist_scaled, dist_gated;

  always_comb begin
    fold_a = (s1_az > lpd_pkg::AZ_FULL) ? s1_az - lpd_pkg::AZ_FULL : s1_az;
    fold_b = (s1_nb > lpd_pkg::AZ_FULL) ? s1_nb - lpd_pkg::AZ_FULL : s1_nb;
    diff   = (fold_a > fold_b) ? fold_a - fold_b : fold_b - fold_a;
    diff_short = (diff > lpd_pkg::AZ_HALF) ? lpd_pkg::AZ_FULL - diff : diff;
    dist_scaled = cfg.protocol_mode ? {s1_dist, 2'b00} : {1'b0, s1_dist, 1'b0};
    dist_gated  = (dist_scaled < cfg.min_range_mm || dist_scaled > cfg.max_range_mm)
                ? '0 : dist_scaled;
  end

  logic [lpd_pkg::AZ_W-1:0]   s2_a;
  logic [lpd_pkg::DIFF_W-1:0] s2_d;
  logic [lpd_pkg::SLOT_W-1:0] s2_slot;
  logic [lpd_pkg::DIST_W-1:0] s2_dist;
  logic [lpd_pkg::STR_W-1:0]  s2_str;

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_a    <= fold_a;
      s2_d    <= diff_short[lpd_pkg::DIFF_W-1:0];
      s2_slot <= s1_slot;
      s2_dist <= dist_gated;
      s2_str  <= s1_str;
    end
  end

  // Stage 3: slot times the block-to-neighbor difference.
  logic [lpd_pkg::AZ_W-1:0]   s3_a;
  logic [lpd_pkg::PROD_W-1:0] s3_p;
  logic [lpd_pkg::DIST_W-1:0] s3_dist;
  logic [lpd_pkg::STR_W-1:0]  s3_str;

  always_ff @(posedge clk) begin
    if (adv3) begin
      s3_a    <= s2_a;
      s3_p    <= lpd_pkg::PROD_W'(s2_slot) * lpd_pkg::PROD_W'(s2_d);
      s3_dist <= s2_dist;
      s3_str  <= s2_str;
    end
  end

  // Stage 4: divide by twice the points per half block (30 or 2), add
  // the block azimuth.
  logic [lpd_pkg::DIV30_PROD_W-1:0] div30_prod;
  logic [lpd_pkg::SUM_W-1:0]        step_q, step_sum;

  always_comb begin
    div30_prod = lpd_pkg::DIV30_PROD_W'(s3_p) *
                 lpd_pkg::DIV30_PROD_W'(lpd_pkg::DIV30_RECIP);
    step_q = cfg.protocol_mode
           ? lpd_pkg::SUM_W'(div30_prod >> lpd_pkg::DIV30_SHIFT)
           : lpd_pkg::SUM_W'(s3_p >> 1);
    step_sum = lpd_pkg::SUM_W'(s3_a) + step_q;
  end

  logic [lpd_pkg::SUM_W-1:0]  s4_t;
  logic [lpd_pkg::DIST_W-1:0] s4_dist;
  logic [lpd_pkg::STR_W-1:0]  s4_str;

  always_ff @(posedge clk) begin
    if (adv4) begin
      s4_t    <= step_sum;
      s4_dist <= s3_dist;
      s4_str  <= s3_str;
    end
  end

  // Stage 5: reduce modulo one turn; the sum stays below nine turns, so
  // count the turn thresholds it passes.
  logic [lpd_pkg::TURN_W-1:0] turns;
  logic [lpd_pkg::SUM_W-1:0]  reduced;

  always_comb begin
    turns = '0;
    for (int k = 1; k <= lpd_pkg::MAX_TURNS; k++) begin
      if (s4_t >= lpd_pkg::turn_base(lpd_pkg::TURN_W'(k))) turns = turns + 1'b1;
    end
    reduced = s4_t - lpd_pkg::turn_base(turns);
  end

  logic [lpd_pkg::AZ_W-1:0]   s5_pa;
  logic [lpd_pkg::DIST_W-1:0] s5_dist;
  logic [lpd_pkg::STR_W-1:0]  s5_str;

  always_ff @(posedge clk) begin
    if (adv5) begin
      s5_pa   <= reduced[lpd_pkg::AZ_W-1:0];
      s5_dist <= s4_dist;
      s5_str  <= s4_str;
    end
  end

  // Result stage: revolution tracking against the last kept azimuth.
  logic [lpd_pkg::AZ_W-1:0] prev_az;
  logic [CNT_W-1:0]         rev_count, rev_count_next, count_inc;
  logic [CNT_W-1:0]         idx_sat;
  logic                     wrap;

  always_comb begin
    wrap = (s5_pa < prev_az) && (prev_az > lpd_pkg::WRAP_HIGH) &&
           (s5_pa < lpd_pkg::WRAP_LOW);
    idx_sat   = (rev_count >= IDX_LAST) ? IDX_LAST : rev_count;
    count_inc = (rev_count < CNT_MAX) ? rev_count + 1'b1 : CNT_MAX;
    rev_count_next = wrap ? '0 : count_inc;
  end

  logic take5;
  assign take5 = advo && v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      vo        <= 1'b0;
      prev_az   <= '0;
      rev_count <= '0;
    end else begin
      if (advo) vo <= v5;
      // Advance the revolution state only when a kept point moves out.
      if (take5) begin
        prev_az   <= s5_pa;
        rev_count <= rev_count_next;
      end
    end
  end

  logic [lpd_pkg::AZ_W-1:0]   o_pa;
  logic [lpd_pkg::DIST_W-1:0] o_dist;
  logic [lpd_pkg::STR_W-1:0]  o_str;
  logic [IDX_W-1:0]           o_idx;
  logic                       o_end;
  logic [CNT_W-1:0]           o_pts;

  always_ff @(posedge clk) begin
    if (advo) begin
      o_pa   <= s5_pa;
      o_dist <= s5_dist;
      o_str  <= s5_str;
      o_idx  <= idx_sat[IDX_W-1:0];
      o_end  <= wrap;
      o_pts  <= wrap ? count_inc : '0;
    end
  end

  assign decoded_point.valid             = vo;
  assign decoded_point.pt_azimuth        = o_pa;
  assign decoded_point.distance_mm       = o_dist;
  assign decoded_point.point_strength    = o_str;
  assign decoded_point.point_index       = o_idx;
  assign decoded_point.revolution_end    = o_end;
  assign decoded_point.revolution_points = o_pts;

endmodule

>>> design/lpd_cfg_regs.sv
// Configuration register file of the point decoder.
module lpd_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [lpd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lpd_pkg::DIST_W-1:0]      cfg_data,
  output lpd_pkg::lpd_cfg_t               cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.protocol_mode <= lpd_pkg::RST_PROTOCOL_MODE;
      cfg.min_range_mm  <= lpd_pkg::RST_MIN_RANGE;
      cfg.max_range_mm  <= lpd_pkg::RST_MAX_RANGE;
      cfg.header_marker <= lpd_pkg::RST_HEADER_MARKER;
    end else if (cfg_we) begin
      case (lpd_pkg::cfg_reg_t'(cfg_index))
        lpd_pkg::CFG_PROTOCOL_MODE: cfg.protocol_mode <= cfg_data[0];
        lpd_pkg::CFG_MIN_RANGE:     cfg.min_range_mm  <= cfg_data;
        lpd_pkg::CFG_MAX_RANGE:     cfg.max_range_mm  <= cfg_data;
        lpd_pkg::CFG_HEADER_MARKER:
          cfg.header_marker <= cfg_data[lpd_pkg::HDR_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

>>> design/lpd_checker.sv
// Port-level assertions of the point decoder and their bind.
module lpd_checker #(
  parameter int MAX_POINTS = 4096
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [lpd_pkg::AZ_W-1:0]      pt_azimuth,
  input logic                          revolution_end,
  input logic [$clog2(MAX_POINTS+1)-1:0] revolution_points
);

  // A stalled word holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pt_azimuth) &&
    $stable(revolution_end) && $stable(revolution_points))
    else $error("decoded word changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("decoded word valid after reset");

  a_azimuth_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pt_azimuth < lpd_pkg::AZ_FULL)
    else $error("azimuth outside one turn");

  a_rev_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && revolution_end |->
      pt_azimuth < lpd_pkg::WRAP_LOW && revolution_points != '0)
    else $error("revolution end with bad azimuth or empty count");

  a_rev_points_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !revolution_end |-> revolution_points == '0)
    else $error("revolution count outside revolution end");

endmodule

bind lidar_point_decoder lpd_checker #(.MAX_POINTS(MAX_POINTS)) u_lpd_checker (
  .clk               (clk),
  .rst               (rst),
  .out_valid         (decoded_point.valid),
  .out_ready         (decoded_point.ready),
  .pt_azimuth        (decoded_point.pt_azimuth),
  .revolution_end    (decoded_point.revolution_end),
  .revolution_points (decoded_point.revolution_points)
);
